// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge once reset has been released.
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, including while reset is held.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/lps_pkg.sv =====
// Package with the widths and codes shared by the line pixel stepper files.
package lps_pkg;

    localparam int COORD_BITS = 12;
    localparam int SPAN_BITS  = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 2;
    localparam int ESUM_BITS  = COORD_BITS + 4;
    localparam int FRAME_BITS = 12;
    localparam int INDEX_BITS = 22;
    localparam int PROD_BITS  = COORD_BITS + FRAME_BITS;
    localparam int RGBA_BITS  = 32;
    localparam int CFG_IDX_BITS = 4;

    typedef enum logic
    {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = CFG_IDX_BITS'(1);

    localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RESET  = FRAME_BITS'(1024);
    localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RESET = FRAME_BITS'(1024);

endpackage

// ===== hw/rtl/line_pixel_stepper_core.sv =====
// Timing: a tick transaction shows its pixel on the output in the cycle after it is taken.
// Throughput: one transaction per cycle; the only limit is the single output register,
// which holds off input only while it is full and stalled.
// Reset: asynchronous, active low; the stepper is idle, the frame is 1024 by 1024
// and no pixel is pending.
module line_pixel_stepper_core
    import lps_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]        cfg_index,
    input  logic [FRAME_BITS-1:0]          cfg_data,
    // Input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           op,
    input  logic signed [COORD_BITS-1:0]   start_x,
    input  logic signed [COORD_BITS-1:0]   start_y,
    input  logic signed [COORD_BITS-1:0]   end_x,
    input  logic signed [COORD_BITS-1:0]   end_y,
    input  logic [RGBA_BITS-1:0]           rgba,
    // Output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [COORD_BITS-1:0]   pixel_x,
    output logic signed [COORD_BITS-1:0]   pixel_y,
    output logic [INDEX_BITS-1:0]          pixel_index,
    output logic [RGBA_BITS-1:0]           pixel_rgba,
    output logic                           on_screen,
    output logic                           last
);

    // Configuration registers
    logic [FRAME_BITS-1:0] frame_width_reg;
    logic [FRAME_BITS-1:0] frame_height_reg;

    // Line state
    logic signed [COORD_BITS-1:0] major_pos_reg, major_pos_next;
    logic signed [COORD_BITS-1:0] major_stop_reg, major_stop_next;
    logic signed [COORD_BITS-1:0] minor_pos_reg, minor_pos_next;
    logic [SPAN_BITS-1:0]         major_span_reg, major_span_next;
    logic [SPAN_BITS-1:0]         minor_span_reg, minor_span_next;
    logic signed [ERR_BITS-1:0]   err_acc_reg, err_acc_next;
    logic                         minor_dir_neg_reg, minor_dir_neg_next;
    logic                         steep_reg, steep_next;
    logic                         busy_reg, busy_next;
    logic [RGBA_BITS-1:0]         line_rgba_reg, line_rgba_next;

    // Output register
    logic                         out_valid_reg, out_valid_next;
    logic signed [COORD_BITS-1:0] pixel_x_reg, pixel_x_next;
    logic signed [COORD_BITS-1:0] pixel_y_reg, pixel_y_next;
    logic [INDEX_BITS-1:0]        pixel_index_reg, pixel_index_next;
    logic [RGBA_BITS-1:0]         pixel_rgba_reg, pixel_rgba_next;
    logic                         on_screen_reg, on_screen_next;
    logic                         last_reg, last_next;

    logic in_accept;
    logic out_accept;
    logic load_pixel;

    // Start decode
    logic signed [SPAN_BITS-1:0]  dx, dy, db;
    logic [SPAN_BITS-1:0]         adx, ady;
    logic                         start_steep;
    logic signed [COORD_BITS-1:0] a0, b0, a1, b1;
    logic signed [COORD_BITS-1:0] fa0, fb0, fa1, fb1;
    logic                         swap;
    logic [SPAN_BITS-1:0]         start_major_span;

    // Step logic
    logic signed [COORD_BITS-1:0] px, py;
    logic                         on;
    logic [PROD_BITS-1:0]         idx_prod;
    logic [PROD_BITS-1:0]         idx_sum;
    logic signed [ESUM_BITS-1:0]  err_sum;
    logic signed [ESUM_BITS-1:0]  err_sum2;
    logic signed [ESUM_BITS-1:0]  span_ext;
    logic                         minor_step;
    logic signed [COORD_BITS-1:0] major_inc;
    logic                         fin;

    assign cfg_ready  = 1'b1;
    assign in_stall   = out_valid_reg && out_stall;
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;
    assign load_pixel = in_accept && (op == OP_TICK) && busy_reg;

    // Start: choose the major axis and order the endpoints along it.
    always_comb
    begin
        dx  = SPAN_BITS'(end_x) - SPAN_BITS'(start_x);
        dy  = SPAN_BITS'(end_y) - SPAN_BITS'(start_y);
        adx = dx[SPAN_BITS-1] ? SPAN_BITS'(-dx) : SPAN_BITS'(dx);
        ady = dy[SPAN_BITS-1] ? SPAN_BITS'(-dy) : SPAN_BITS'(dy);
        start_steep = ady > adx;

        a0 = start_steep ? start_y : start_x;
        b0 = start_steep ? start_x : start_y;
        a1 = start_steep ? end_y : end_x;
        b1 = start_steep ? end_x : end_y;

        swap = a1 < a0;
        fa0  = swap ? a1 : a0;
        fb0  = swap ? b1 : b0;
        fa1  = swap ? a0 : a1;
        fb1  = swap ? b0 : b1;

        start_major_span = SPAN_BITS'(SPAN_BITS'(fa1) - SPAN_BITS'(fa0));
        db = SPAN_BITS'(fb1) - SPAN_BITS'(fb0);
    end

    // Tick: current pixel, its frame index and the error update.
    always_comb
    begin
        px = steep_reg ? minor_pos_reg : major_pos_reg;
        py = steep_reg ? major_pos_reg : minor_pos_reg;

        on = !px[COORD_BITS-1] && !py[COORD_BITS-1]
            && (PROD_BITS'(unsigned'(px)) < PROD_BITS'(frame_width_reg))
            && (PROD_BITS'(unsigned'(py)) < PROD_BITS'(frame_height_reg));

        idx_prod = PROD_BITS'(unsigned'(py)) * PROD_BITS'(frame_width_reg);
        idx_sum  = idx_prod + PROD_BITS'(unsigned'(px));

        // The minor axis advances when twice the running error reaches the major span.
        err_sum    = ESUM_BITS'(err_acc_reg) + signed'(ESUM_BITS'(minor_span_reg));
        err_sum2   = err_sum <<< 1;
        span_ext   = signed'(ESUM_BITS'(major_span_reg));
        minor_step = err_sum2 >= span_ext;

        major_inc = major_pos_reg + COORD_BITS'(1);
        fin       = major_inc == major_stop_reg;
    end

    always_comb
    begin
        major_pos_next     = major_pos_reg;
        major_stop_next    = major_stop_reg;
        minor_pos_next     = minor_pos_reg;
        major_span_next    = major_span_reg;
        minor_span_next    = minor_span_reg;
        err_acc_next       = err_acc_reg;
        minor_dir_neg_next = minor_dir_neg_reg;
        steep_next         = steep_reg;
        busy_next          = busy_reg;
        line_rgba_next     = line_rgba_reg;

        if (in_accept && (op == OP_START))
        begin
            major_pos_next     = fa0;
            major_stop_next    = fa1;
            minor_pos_next     = fb0;
            major_span_next    = start_major_span;
            minor_span_next    = db[SPAN_BITS-1] ? SPAN_BITS'(-db) : SPAN_BITS'(db);
            minor_dir_neg_next = db[SPAN_BITS-1];
            err_acc_next       = '0;
            steep_next         = start_steep;
            busy_next          = start_major_span != '0;
            line_rgba_next     = rgba;
        end
        else if (load_pixel)
        begin
            major_pos_next = major_inc;
            if (minor_step)
            begin
                minor_pos_next = minor_dir_neg_reg ? minor_pos_reg - COORD_BITS'(1)
                                                   : minor_pos_reg + COORD_BITS'(1);
                err_acc_next   = ERR_BITS'(err_sum - span_ext);
            end
            else
            begin
                err_acc_next = ERR_BITS'(err_sum);
            end
            if (fin)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        pixel_x_next     = pixel_x_reg;
        pixel_y_next     = pixel_y_reg;
        pixel_index_next = pixel_index_reg;
        pixel_rgba_next  = pixel_rgba_reg;
        on_screen_next   = on_screen_reg;
        last_next        = last_reg;

        if (out_accept)
        begin
            out_valid_next = 1'b0;
        end
        if (load_pixel)
        begin
            out_valid_next   = 1'b1;
            pixel_x_next     = px;
            pixel_y_next     = py;
            pixel_index_next = on ? idx_sum[INDEX_BITS-1:0] : '0;
            pixel_rgba_next  = line_rgba_reg;
            on_screen_next   = on;
            last_next        = fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_FRAME_WIDTH)
            begin
                frame_width_reg <= cfg_data;
            end
            else if (cfg_index == CFG_FRAME_HEIGHT)
            begin
                frame_height_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            major_pos_reg     <= '0;
            major_stop_reg    <= '0;
            minor_pos_reg     <= '0;
            major_span_reg    <= '0;
            minor_span_reg    <= '0;
            err_acc_reg       <= '0;
            minor_dir_neg_reg <= 1'b0;
            steep_reg         <= 1'b0;
            busy_reg          <= 1'b0;
            line_rgba_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            major_pos_reg     <= major_pos_next;
            major_stop_reg    <= major_stop_next;
            minor_pos_reg     <= minor_pos_next;
            major_span_reg    <= major_span_next;
            minor_span_reg    <= minor_span_next;
            err_acc_reg       <= err_acc_next;
            minor_dir_neg_reg <= minor_dir_neg_next;
            steep_reg         <= steep_next;
            busy_reg          <= busy_next;
            line_rgba_reg     <= line_rgba_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_x_reg     <= pixel_x_next;
        pixel_y_reg     <= pixel_y_next;
        pixel_index_reg <= pixel_index_next;
        pixel_rgba_reg  <= pixel_rgba_next;
        on_screen_reg   <= on_screen_next;
        last_reg        <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_index = pixel_index_reg;
    assign pixel_rgba  = pixel_rgba_reg;
    assign on_screen   = on_screen_reg;
    assign last        = last_reg;

endmodule

// ===== hw/rtl/lps_checker.sv =====
// Port-level checker for the line pixel stepper, bound to the stepper core.
`include "assert_macros.svh"

module lps_checker
    import lps_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    op,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [INDEX_BITS-1:0]   pixel_index,
    input logic                    on_screen
);

    // A held result must stay offered until it is taken.
    `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "stalled result dropped")

    // Input is held off only while a finished result waits on a stalled output.
    `ASSERT_ALWAYS(a_stall_cause, clk, in_stall |-> (out_valid && out_stall), "input stalled without a pending result")

    // A start transaction never produces a pixel.
    `ASSERT_CLK(a_start_silent, clk, rst_n, (in_valid && !in_stall && (op == OP_START) && !(out_valid && out_stall)) |=> !out_valid, "start produced a pixel")

    // Pixels outside the frame carry a zero index.
    `ASSERT_CLK(a_offscreen_idx, clk, rst_n, (out_valid && !on_screen) |-> (pixel_index == '0), "off-screen pixel has a nonzero index")

endmodule

bind line_pixel_stepper_core lps_checker u_lps_checker (.*);
